### rtl/core/toch_pkg.sv
// ----------------------------------------------------------------------------
// toch_pkg: shared types and constants of the checkpoint history
// Command codes, sequencer states, stream widths and the control and flag
// bundles that pass between the sequencer and the row of history cells.
// ----------------------------------------------------------------------------
package toch_pkg;

	localparam int TICK_W    = 64;
	localparam int HANDLE_W  = 64;
	localparam int CAP_W     = 5;
	localparam int CNT_OUT_W = 5;
	localparam int CMD_W     = 2;

	// Packed field widths of the two streams, rounded up to whole bytes.
	localparam int S_FIELDS_W = TICK_W + HANDLE_W + 1;
	localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int M_FIELDS_W = 1 + HANDLE_W + CNT_OUT_W + 1 + TICK_W + TICK_W;
	localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	localparam logic [CMD_W-1:0] CMD_CAPTURE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RESTORE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DISCARD = 2'd2;
	localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_EVAL,
		ST_DROP,
		ST_WRITE,
		ST_TRIM,
		ST_DONE
	} toch_state_t;

	// Broadcast to every cell in the row.
	typedef struct packed {
		logic cmp;    // register the comparison flags against the key
		logic shift;  // take the neighbour's entry (shift towards the oldest end)
		logic load;   // the selected cell takes the new entry
	} cell_ctl_t;

	// Comparison of a cell's tick against the key, already masked by occupancy.
	typedef struct packed {
		logic lt;
		logic le;
		logic eq;
	} cell_flags_t;

endpackage

### rtl/core/toch_cell.sv
// ----------------------------------------------------------------------------
// toch_cell: one slot of the checkpoint history row
// Holds one (tick, handle) pair, compares it against the broadcast key and
// hands its entry to the neighbour on the older side when the row shifts.
// ----------------------------------------------------------------------------
module toch_cell
	import toch_pkg::*;
(
	input  logic                clk,
	input  cell_ctl_t           ctl,
	input  logic                sel,
	input  logic                valid,
	input  logic                last,
	input  logic [TICK_W-1:0]   key,
	input  logic [HANDLE_W-1:0] new_handle,
	input  logic [TICK_W-1:0]   nb_tick,
	input  logic [HANDLE_W-1:0] nb_handle,
	output logic [TICK_W-1:0]   tick,
	output logic [HANDLE_W-1:0] handle,
	output logic [HANDLE_W-1:0] hit_handle,
	output logic [TICK_W-1:0]   last_tick,
	output cell_flags_t         flags
);

	logic [TICK_W-1:0]   tick_q;
	logic [HANDLE_W-1:0] handle_q;
	cell_flags_t         flags_q;

	always_ff @(posedge clk) begin
		if (ctl.load && sel) begin
			tick_q   <= key;
			handle_q <= new_handle;
		end else if (ctl.shift) begin
			tick_q   <= nb_tick;
			handle_q <= nb_handle;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.cmp) begin
			flags_q.lt <= tick_q < key;
			flags_q.le <= tick_q <= key;
			flags_q.eq <= tick_q == key;
		end
	end

	// Flags of an empty slot are forced low so the row reads as a clean prefix.
	assign flags.lt   = flags_q.lt & valid;
	assign flags.le   = flags_q.le & valid;
	assign flags.eq   = flags_q.eq & valid;
	assign tick       = tick_q;
	assign handle     = handle_q;
	assign hit_handle = flags.eq ? handle_q : '0;
	assign last_tick  = last ? tick_q : '0;

endmodule

### rtl/core/tick_ordered_checkpoint_history_unit.sv
// ----------------------------------------------------------------------------
// tick_ordered_checkpoint_history_unit: sorted history of checkpoints
// Keeps up to DEPTH (tick, handle) checkpoints, trimmed to the capacity on
// each stored capture, in ascending tick order in a row of cells, oldest in
// cell 0, and serves capture, restore lookup, discard-after and query requests.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Signals                     Contents
//  s_*       in         s_tvalid s_tready s_tdata   tick, snapshot_ref, save_ok
//                       s_tuser                     cmd
//  m_*       out        m_tvalid m_tready m_tdata   ok, restored_ref, entry_count,
//                                                   has_entries, oldest/latest tick
//  cfg_*     in         cfg_wen cfg_wdata           capacity
//
// A restore, discard or query request runs through a compare state, a
// decision state and a result state before the sequencer is idle again, and
// so does a capture that fails; a capture that stores its entry also runs
// through a write state and a closing trim check, with a drop of the oldest
// entry first when the row is full and all its ticks are older than the new
// one, and the trim check drops the oldest entry once more for every entry
// above a capacity that was lowered earlier. The single sequencer drives the row.
// A new request is taken whenever the sequencer is idle, even while the last
// result still waits in the output register; a stalled result only holds the
// sequencer in its final state. Reset clears the sequencer, the entry count,
// the output valid flag and the capacity (to 16); cell contents are not reset
// and are never read before being written.
// ----------------------------------------------------------------------------
module tick_ordered_checkpoint_history_unit
	import toch_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// [63:0] tick, [127:64] snapshot_ref, [128] save_ok, rest zero
	input  logic [S_TDATA_W-1:0] s_tdata,
	// [1:0] cmd
	input  logic [CMD_W-1:0]     s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// [0] ok, [64:1] restored_ref, [69:65] entry_count, [70] has_entries,
	// [134:71] oldest_tick, [198:135] latest_tick, rest zero
	output logic [M_TDATA_W-1:0] m_tdata,
	input  logic                 cfg_wen,
	input  logic [CAP_W-1:0]     cfg_wdata
);

	// Count width covers 0..DEPTH; capacity comparisons use the wider of the two.
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CAPW = (CW > CAP_W) ? CW : CAP_W;

	toch_state_t state_q, state_nxt;

	logic [CAP_W-1:0]    capacity_q;
	logic [CW-1:0]       count_q;
	logic [CMD_W-1:0]    cmd_q;
	logic [TICK_W-1:0]   key_q;
	logic [HANDLE_W-1:0] new_handle_q;
	logic                save_ok_q;
	logic                ok_q;
	logic [HANDLE_W-1:0] found_q;
	logic                m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	cell_ctl_t ctl;

	logic [TICK_W-1:0]   tick_v       [DEPTH];
	logic [HANDLE_W-1:0] handle_v     [DEPTH];
	logic [HANDLE_W-1:0] hit_handle_v [DEPTH];
	logic [TICK_W-1:0]   last_tick_v  [DEPTH];
	cell_flags_t         flags_v      [DEPTH];
	logic [DEPTH-1:0]    sel_v, valid_v, last_v, hit_v;
	logic [DEPTH:0]      lt_ext, le_ext;

	logic [CW-1:0]       pos_lt, pos_le;
	logic                hit_any;
	logic [HANDLE_W-1:0] hit_handle;
	logic [TICK_W-1:0]   latest_tick;
	logic [TICK_W-1:0]   oldest_tick;
	logic [CAPW-1:0]     cap_sat;
	logic                over_cap;
	logic                in_fire;
	logic                out_free;

	assign in_fire  = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// Capacity above the row length behaves as the row length.
	assign cap_sat  = (CAPW'(capacity_q) > CAPW'(DEPTH)) ? CAPW'(DEPTH) : CAPW'(capacity_q);
	assign over_cap = CAPW'(count_q) > cap_sat;

	// ---------------------------------------------------------------- cell row
	// Each cell knows from the count whether it is occupied, whether it is the
	// newest entry and whether it is the slot a capture writes into.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [TICK_W-1:0]   nb_tick;
		logic [HANDLE_W-1:0] nb_handle;

		assign valid_v[i] = CW'(i) < count_q;
		assign last_v[i]  = CW'(i + 1) == count_q;
		assign sel_v[i]   = CW'(i) == count_q;

		if (i < DEPTH - 1) begin : g_nb
			assign nb_tick   = tick_v[i + 1];
			assign nb_handle = handle_v[i + 1];
		end else begin : g_end
			assign nb_tick   = '0;
			assign nb_handle = '0;
		end

		toch_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.sel        (sel_v[i]),
			.valid      (valid_v[i]),
			.last       (last_v[i]),
			.key        (key_q),
			.new_handle (new_handle_q),
			.nb_tick    (nb_tick),
			.nb_handle  (nb_handle),
			.tick       (tick_v[i]),
			.handle     (handle_v[i]),
			.hit_handle (hit_handle_v[i]),
			.last_tick  (last_tick_v[i]),
			.flags      (flags_v[i])
		);

		assign lt_ext[i] = flags_v[i].lt;
		assign le_ext[i] = flags_v[i].le;
		assign hit_v[i]  = flags_v[i].eq;
	end

	assign lt_ext[DEPTH] = 1'b0;
	assign le_ext[DEPTH] = 1'b0;

	// Ticks are strictly ascending, so the lt and le flags form a prefix of
	// ones. The end of each prefix is a one-hot mark whose position gives the
	// insertion point (lt) or the number of entries that survive a discard
	// (le). At most one occupied cell can match a restore exactly.
	always_comb begin
		pos_lt      = '0;
		pos_le      = '0;
		hit_handle  = '0;
		latest_tick = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (lt_ext[i] && !lt_ext[i + 1]) begin
				pos_lt = pos_lt | CW'(i + 1);
			end
			if (le_ext[i] && !le_ext[i + 1]) begin
				pos_le = pos_le | CW'(i + 1);
			end
			hit_handle  = hit_handle | hit_handle_v[i];
			latest_tick = latest_tick | last_tick_v[i];
		end
	end

	assign hit_any     = |hit_v;
	assign oldest_tick = (count_q != '0) ? tick_v[0] : '0;

	// --------------------------------------------------------------- sequencer
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) state_nxt = ST_CMP;
			end
			ST_CMP: begin
				state_nxt = ST_EVAL;
			end
			ST_EVAL: begin
				state_nxt = ST_DONE;
				if (cmd_q == CMD_CAPTURE && cap_sat != '0 && save_ok_q) begin
					// A full row whose ticks all lie before the key first gives up its oldest entry.
					state_nxt = (pos_lt == CW'(DEPTH)) ? ST_DROP : ST_WRITE;
				end
			end
			ST_DROP: begin
				state_nxt = ST_WRITE;
			end
			ST_WRITE: begin
				state_nxt = ST_TRIM;
			end
			ST_TRIM: begin
				if (!over_cap) state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl.cmp   = 1'b0;
		ctl.shift = 1'b0;
		ctl.load  = 1'b0;
		unique case (state_q)
			ST_CMP:   ctl.cmp   = 1'b1;
			ST_DROP:  ctl.shift = 1'b1;
			ST_WRITE: ctl.load  = 1'b1;
			ST_TRIM:  ctl.shift = over_cap;
			default: begin
				ctl.cmp = 1'b0;
			end
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			capacity_q <= CAP_RESET;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_wen) begin
				capacity_q <= cfg_wdata;
			end
			case (state_q)
				ST_EVAL: begin
					if (cmd_q == CMD_CAPTURE && cap_sat != '0 && save_ok_q) begin
						count_q <= pos_lt;
					end else if (cmd_q == CMD_DISCARD) begin
						count_q <= pos_le;
					end
				end
				ST_DROP:  count_q <= count_q - 1'b1;
				ST_WRITE: count_q <= count_q + 1'b1;
				ST_TRIM: begin
					if (over_cap) count_q <= count_q - 1'b1;
				end
				default: begin
					count_q <= count_q;
				end
			endcase
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Request and result payload.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q        <= s_tuser;
			key_q        <= s_tdata[TICK_W-1:0];
			new_handle_q <= s_tdata[TICK_W +: HANDLE_W];
			save_ok_q    <= s_tdata[TICK_W + HANDLE_W];
			ok_q         <= 1'b1;
			found_q      <= '0;
		end else if (state_q == ST_EVAL) begin
			if (cmd_q == CMD_CAPTURE) begin
				ok_q <= (cap_sat != '0) && save_ok_q;
			end else if (cmd_q == CMD_RESTORE) begin
				ok_q    <= hit_any;
				found_q <= hit_handle;
			end
		end
		if (state_q == ST_DONE && out_free) begin
			m_tdata_q <= M_TDATA_W'({latest_tick, oldest_tick, (count_q != '0),
				CNT_OUT_W'(count_q), found_q, ok_q});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// -------------------------------------------------------------- assertions
	count_in_range_a: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count exceeds the row length");

	restore_single_hit_a: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVAL) |-> $onehot0(hit_v))
		else $error("more than one cell matches the key");

	write_grows_count_a: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE) |=> (count_q == $past(count_q) + 1'b1))
		else $error("capture write did not add one entry");

	busy_blocks_input_a: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_tready)
		else $error("request accepted while the sequencer is busy");

	trim_done_a: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TRIM && !over_cap) |=> (state_q == ST_DONE))
		else $error("trim did not hand over to the result stage");

endmodule
